// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted tag set.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TAG_W    = 16;
    localparam int ACT_W    = 2;
    localparam int ECNT_W   = 7;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [TAG_W-1:0] tag;
    } sts_req_t;

    typedef struct packed {
        logic              hit;
        logic              overflow;
        logic [ECNT_W-1:0] entry_count;
    } sts_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } sts_state_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic commit;
    } sts_cmd_t;

endpackage

// ===== rtl/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer: capture request, compare all cells, commit update and result.
// ----------------------------------------------------------------------------
module sts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    output sts_pkg::sts_cmd_t cmd
);
    import sts_pkg::*;

    sts_state_t state_reg;
    sts_state_t state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        done_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
            end
            ST_UPD:
            begin
                cmd.commit = 1'b1;
                done_next  = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/sts_dpath.sv =====
// ----------------------------------------------------------------------------
// sts_dpath
// Row of tag cells with per-cell compare, shift insert/remove and count.
// ----------------------------------------------------------------------------
module sts_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  sts_pkg::sts_cmd_t cmd,
    input  sts_pkg::sts_req_t req,
    output sts_pkg::sts_rsp_t rsp
);
    import sts_pkg::*;

    sts_req_t             req_reg;
    logic [TAG_W-1:0]     cell_reg [CAPACITY];
    logic [TAG_W-1:0]     cell_next [CAPACITY];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CAPACITY-1:0]  lt_reg;
    logic [CAPACITY-1:0]  lt_next;
    logic [CAPACITY-1:0]  eq_reg;
    logic [CAPACITY-1:0]  eq_next;
    logic [CAPACITY-1:0]  bound;
    sts_rsp_t             rsp_reg;
    sts_rsp_t             rsp_next;
    logic                 found;
    logic                 full;

    // lt marks the prefix of valid cells below the tag; bound is the first cell after it
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_next[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] < req_reg.tag);
            eq_next[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] == req_reg.tag);
        end
    end

    always_comb
    begin
        bound[0] = !lt_reg[0];
        for (int i = 1; i < CAPACITY; i++)
        begin
            bound[i] = !lt_reg[i] && lt_reg[i-1];
        end
    end

    assign found = |(bound & eq_reg);
    assign full  = (count_reg >= CNT_W'(CAPACITY));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        count_next           = count_reg;
        rsp_next.hit         = 1'b0;
        rsp_next.overflow    = 1'b0;
        case (req_reg.action)
            ACT_INSERT:
            begin
                if (full)
                begin
                    rsp_next.overflow = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (bound[i])
                        begin
                            cell_next[i] = req_reg.tag;
                        end
                        else if (!lt_reg[i] && i > 0)
                        begin
                            cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
            end
            ACT_REMOVE:
            begin
                if (found)
                begin
                    rsp_next.hit = 1'b1;
                    count_next   = count_reg - 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (!lt_reg[i])
                        begin
                            cell_next[i] = cell_reg[i+1];
                        end
                    end
                end
            end
            ACT_FIND:
            begin
                rsp_next.hit = found;
            end
            default:
            begin
                rsp_next.hit = 1'b0;
            end
        endcase
        rsp_next.entry_count = ECNT_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.compare)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= cell_next[i];
            end
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/sorted_tag_set.sv =====
// ----------------------------------------------------------------------------
// sorted_tag_set
// Bounded ascending multiset of 16-bit tags: insert, remove one copy, find.
//
//   channel   signals             transfer
//   request   start, busy, req    start high while busy low
//   result    done, rsp           done high for one cycle, always taken
//
// Each request runs capture, then a parallel compare of all cells,
// then commit of the shifted row, the count and the result register.
// done rises the cycle after commit; a new request may start in that cycle.
// Reset clears the count and the sequencer; cell contents need no reset.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_tag_set (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sts_pkg::sts_req_t req,
    output logic              done,
    output sts_pkg::sts_rsp_t rsp
);
    import sts_pkg::*;

    sts_cmd_t cmd;

    sts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    sts_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.entry_count <= ECNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.overflow |-> rsp.entry_count == ECNT_W'(CAPACITY) && !rsp.hit)
        else $error("overflow reported while not full");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_tag_set: insert, remove and find on a sorted multiset.
//
// A short directed table runs first: empty-store lookups, the unused action
// code, extreme tags, duplicates and removal of absent tags. Random phases
// follow. Each phase fills the store past capacity and then drains it. The
// sender idles at a rate that changes from phase to phase. Every accepted
// request goes through a shadow copy of the sorted store. Each result is
// compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

    import sts_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RAND_ITEMS = 852;
    localparam int GAP_MAX    = 40;
    localparam int WD_LIMIT   = 1000;
    localparam int TAIL_WAIT  = 10;

    typedef struct packed {
        sts_req_t r;
        logic     typed;
        sts_rsp_t want;
    } dir_row_t;

    localparam int DIR_N = 18;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{'{ACT_FIND,   16'h0000}, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{'{ACT_REMOVE, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{'{ACT_UNUSED, 16'h1234}, 1'b1, '{1'b0, 1'b0, 7'd0}},
        '{'{ACT_INSERT, 16'hFFFF}, 1'b1, '{1'b0, 1'b0, 7'd1}},
        '{'{ACT_INSERT, 16'h0000}, 1'b1, '{1'b0, 1'b0, 7'd2}},
        '{'{ACT_FIND,   16'hFFFF}, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{'{ACT_FIND,   16'h0000}, 1'b1, '{1'b1, 1'b0, 7'd2}},
        '{'{ACT_INSERT, 16'h8000}, 1'b0, '0},
        '{'{ACT_INSERT, 16'h8000}, 1'b0, '0},
        '{'{ACT_FIND,   16'h7FFF}, 1'b0, '0},
        '{'{ACT_REMOVE, 16'h8000}, 1'b0, '0},
        '{'{ACT_FIND,   16'h8000}, 1'b0, '0},
        '{'{ACT_REMOVE, 16'h8001}, 1'b0, '0},
        '{'{ACT_UNUSED, 16'hFFFF}, 1'b0, '0},
        '{'{ACT_INSERT, 16'h5555}, 1'b0, '0},
        '{'{ACT_INSERT, 16'hAAAA}, 1'b0, '0},
        '{'{ACT_REMOVE, 16'h0000}, 1'b0, '0},
        '{'{ACT_FIND,   16'h0000}, 1'b0, '0}
    };

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    sts_req_t req;
    logic     done;
    sts_rsp_t rsp;

    logic             cur_typed;
    sts_rsp_t         cur_want;
    logic [TAG_W-1:0] held_tags [$];
    sts_rsp_t         pending_rsp [$];
    int               errors;
    int               quiet_cycles;
    int               idle_pct;

    sorted_tag_set DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // shadow copy of the sorted store; returns the result the request causes
    function automatic sts_rsp_t apply_request(input sts_req_t r);
        sts_rsp_t o;
        int       pos;
        o   = '0;
        pos = 0;
        while (pos < held_tags.size() && held_tags[pos] < r.tag)
            pos++;
        case (r.action)
            ACT_INSERT:
            begin
                if (held_tags.size() >= CAPACITY)
                    o.overflow = 1'b1;
                else
                    held_tags.insert(pos, r.tag);
            end
            ACT_REMOVE:
            begin
                if (pos < held_tags.size() && held_tags[pos] == r.tag)
                begin
                    held_tags.delete(pos);
                    o.hit = 1'b1;
                end
            end
            ACT_FIND:
            begin
                if (pos < held_tags.size() && held_tags[pos] == r.tag)
                    o.hit = 1'b1;
            end
            default: ;
        endcase
        o.entry_count = ECNT_W'(held_tags.size());
        return o;
    endfunction

    function automatic sts_req_t rand_req(input bit fill);
        sts_req_t r;
        int       p;
        int       reuse_pct;
        p = $urandom_range(99);
        if (fill)
        begin
            r.action  = (p < 80) ? ACT_INSERT : (p < 90) ? ACT_REMOVE :
                        (p < 98) ? ACT_FIND : ACT_UNUSED;
            reuse_pct = 50;
        end
        else
        begin
            r.action  = (p < 10) ? ACT_INSERT : (p < 88) ? ACT_REMOVE :
                        (p < 97) ? ACT_FIND : ACT_UNUSED;
            reuse_pct = 85;
        end
        if (held_tags.size() != 0 && $urandom_range(99) < reuse_pct)
            r.tag = held_tags[$urandom_range(held_tags.size() - 1)];
        else
            r.tag = TAG_W'($urandom);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_req(input sts_req_t r, input logic typed, input sts_rsp_t want);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = r;
        cur_typed = typed;
        cur_want  = want;
        start     = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic wait_results;
        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        sts_rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result transfer with nothing pending");
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
                        errors++;
                    end
                    if (rsp.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", want.overflow, rsp.overflow);
                        errors++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = apply_request(req);
                if (cur_typed)
                    want = cur_want;
                pending_rsp.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("FAIL sorted_tag_set");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cur_typed    = 1'b0;
        cur_want     = '0;
        errors       = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_req(DIR_ROWS[i].r, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        wait_results();

        // idle phases: none, sender 66%, none, sender 8%
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 66 : (ph == 3) ? 8 : 0;
            for (int n = 0; n < RAND_ITEMS / 4; n++)
                send_req(rand_req(n < RAND_ITEMS / 8), 1'b0, '0);
            wait_results();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("PASS sorted_tag_set");
        else
            $display("FAIL sorted_tag_set");
        $finish;
    end

endmodule
